// File: design/lbpm_pkg.sv
package lbpm_pkg;

  localparam int unsigned MaxNeighborsDef = 16;
  localparam int unsigned PatternW        = 16;
  localparam int unsigned LabelW          = 16;
  localparam int unsigned CountW          = 17;
  localparam int unsigned NeighborW       = 5;
  localparam int unsigned CfgIndexW       = 4;
  localparam int unsigned CfgDataW        = 5;

  // Rank table for the widest pattern lives in a RAM filled after reset.
  localparam int unsigned LargeP     = 16;
  localparam int unsigned RankAw     = LargeP;
  localparam int unsigned RankDepth  = 1 << LargeP;
  localparam int unsigned Classes4   = 6;
  localparam int unsigned Classes8   = 36;
  localparam int unsigned Classes16  = 4116;
  localparam int unsigned RankW      = $clog2(Classes16 + 1);
  localparam int unsigned SmallRankW = $clog2(Classes8);
  localparam int unsigned SmallTabN  = 256;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueLvW   = $clog2(QueueDepth + 1);
  localparam int unsigned OutDepth   = 3;
  localparam int unsigned OutLvW     = $clog2(OutDepth + 1);

  typedef enum logic [CfgIndexW-1:0] {
    REG_NUM_NEIGHBORS = 4'd0,
    REG_UNIFORM_MODE  = 4'd1,
    REG_ROT_INV       = 4'd2,
    REG_AVERAGE_BIT   = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [NeighborW-1:0] num_neighbors;
    logic                 uniform_mode;
    logic                 rot_inv;
    logic                 average_bit;
  } cfg_t;

  // Classified item; label carries the raw pattern when use_rank is set.
  typedef struct packed {
    logic              use_rank;
    logic              invalid;
    logic [CountW-1:0] count;
    logic [LabelW-1:0] label;
  } cls_t;

  typedef struct packed {
    logic [LabelW-1:0] label;
    logic [CountW-1:0] count;
    logic              invalid;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [RankAw-1:0] waddr;
    logic [RankW-1:0]  wdata;
    logic [RankAw-1:0] raddr;
  } fill_port_t;

  typedef logic [SmallTabN-1:0][SmallRankW-1:0] rank_tab_t;

  // Rank of each pattern's rotation class, classes ordered by smallest member.
  function automatic rank_tab_t build_rank_table(input int unsigned p);
    rank_tab_t   tab;
    int unsigned code;
    int unsigned c;
    int unsigned s;
    int unsigned m;
    int unsigned r;
    int unsigned mask;
    tab  = '0;
    code = 0;
    mask = (1 << p) - 1;
    for (c = 0; c < (1 << p); c++) begin
      m = c;
      for (s = 1; s < p; s++) begin
        r = ((c >> s) | (c << (p - s))) & mask;
        if (r < m) m = r;
      end
      if (m == c) begin
        tab[c] = SmallRankW'(code);
        code++;
      end else begin
        tab[c] = tab[m];
      end
    end
    return tab;
  endfunction

  localparam rank_tab_t Rank4Tab = build_rank_table(4);
  localparam rank_tab_t Rank8Tab = build_rank_table(8);

endpackage

// File: design/lbpm_ram.sv
module lbpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: design/lbpm_queue.sv
module lbpm_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           head,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  rd_ptr;
  logic [PtrW-1:0]  wr_ptr;

  assign head  = mem[rd_ptr];
  assign empty = (level == '0);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

// File: design/lbpm_front.sv
module lbpm_front import lbpm_pkg::*; #(
  parameter int unsigned MAX_NEIGHBORS = MaxNeighborsDef
) (
  input  cfg_t                cfg,
  input  logic [PatternW-1:0] pattern,
  output cls_t                entry
);

  logic [NeighborW-1:0] p;
  logic                 special;
  logic                 std_p;
  logic                 ok;
  logic [NeighborW-1:0] width;
  logic                 overwide;
  logic [PatternW-1:0]  nb;
  logic [PatternW-1:0]  trans_vec;
  logic [PatternW-1:0]  fall_vec;
  logic [NeighborW-1:0] ones;
  logic [NeighborW-1:0] trans;
  logic [3:0]           top;
  logic [8:0]           lbl_u;
  logic [LabelW-1:0]    lbl_ri;
  logic [CountW-1:0]    count;

  assign p       = cfg.num_neighbors;
  assign special = cfg.uniform_mode | cfg.rot_inv | cfg.average_bit;
  assign std_p   = (p == 5'd4) || (p == 5'd8) || (p == 5'd16);
  assign ok      = (p >= 5'd4) && (p <= 5'd16) && (32'(p) <= MAX_NEIGHBORS) &&
                   !(special && !std_p) && !((p == 5'd16) && cfg.average_bit);

  // The average bit widens only plain patterns.
  assign width = (!cfg.uniform_mode && !cfg.rot_inv && cfg.average_bit) ?
                 p + 5'd1 : p;
  assign overwide = (pattern >> width) != '0;

  // Circular neighbour of each bit, wrapping at bit P-1.
  always_comb begin
    for (int i = 0; i < PatternW; i++) begin
      nb[i]        = (i == int'(p) - 1) ? pattern[0] : pattern[(i + 1) & (PatternW - 1)];
      trans_vec[i] = (i < int'(p)) && (pattern[i] != nb[i]);
      fall_vec[i]  = (i < int'(p)) && pattern[i] && !nb[i];
    end
  end

  assign ones  = NeighborW'($countones(pattern));
  assign trans = NeighborW'($countones(trans_vec));

  always_comb begin
    top = '0;
    for (int i = 0; i < PatternW; i++) begin
      if (fall_vec[i]) top = top | 4'(i);
    end
  end

  always_comb begin
    if (trans > 5'd2) begin
      lbl_u = '0;
    end else if (ones == '0) begin
      lbl_u = 9'd1;
    end else if (ones == p) begin
      lbl_u = cfg.rot_inv ? 9'(p) + 9'd1 : 9'(p) * 9'(p - 5'd1) + 9'd2;
    end else if (cfg.rot_inv) begin
      lbl_u = 9'(ones) + 9'd1;
    end else begin
      lbl_u = 9'd2 + 9'(ones - 5'd1) * 9'(p) + (9'(p) - 9'd1 - 9'(top));
    end
  end

  always_comb begin
    case (p)
      5'd4:    lbl_ri = LabelW'(Rank4Tab[{4'b0, pattern[3:0]}]);
      5'd8:    lbl_ri = LabelW'(Rank8Tab[pattern[7:0]]);
      default: lbl_ri = pattern;
    endcase
  end

  always_comb begin
    if (cfg.rot_inv && cfg.uniform_mode) begin
      count = CountW'(p) + CountW'(2);
    end else if (cfg.rot_inv) begin
      case (p)
        5'd4:    count = CountW'(Classes4);
        5'd8:    count = CountW'(Classes8);
        default: count = CountW'(Classes16);
      endcase
    end else if (cfg.uniform_mode) begin
      count = CountW'(10'(p) * 10'(p - 5'd1)) + CountW'(3);
    end else begin
      count = CountW'(1) << width;
    end
  end

  always_comb begin
    entry = '0;
    if (!ok) begin
      entry.invalid = 1'b1;
    end else if (overwide) begin
      entry.invalid = 1'b1;
      entry.count   = count;
    end else begin
      entry.count = count;
      if (cfg.uniform_mode) begin
        entry.label = LabelW'(lbl_u);
      end else if (cfg.rot_inv) begin
        entry.label    = lbl_ri;
        entry.use_rank = (p == 5'd16);
      end else begin
        entry.label = pattern;
      end
    end
  end

endmodule

// File: design/lbpm_rank_fill.sv
module lbpm_rank_fill import lbpm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [RankW-1:0] rdata,
  output fill_port_t       port,
  output logic             busy
);

  typedef enum logic [3:0] {
    FILL_SCAN = 4'b0001,
    FILL_LOOK = 4'b0010,
    FILL_COPY = 4'b0100,
    FILL_DONE = 4'b1000
  } fill_state_t;

  fill_state_t         state;
  logic [RankAw-1:0]   code;
  logic [1:0]          group;
  logic [RankAw-1:0]   min_val;
  logic [RankW-1:0]    next_rank;
  logic [RankAw-1:0]   rot_cand [4];
  logic [RankAw-1:0]   scan_min;
  logic                last;

  // Four rotations of the current code per cycle.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rot_cand[j] = RankAw'({code, code} >> {group, 2'(j)});
    end
  end

  always_comb begin
    scan_min = min_val;
    for (int j = 0; j < 4; j++) begin
      if (rot_cand[j] < scan_min) scan_min = rot_cand[j];
    end
  end

  assign last       = (code == '1);
  assign busy       = (state != FILL_DONE);
  assign port.we    = ((state == FILL_LOOK) && (min_val == code)) || (state == FILL_COPY);
  assign port.waddr = code;
  assign port.wdata = (state == FILL_COPY) ? rdata : next_rank;
  assign port.raddr = min_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FILL_SCAN;
      code      <= '0;
      group     <= '0;
      min_val   <= '0;
      next_rank <= '0;
    end else begin
      case (state)
        FILL_SCAN: begin
          min_val <= scan_min;
          group   <= group + 1'b1;
          if (group == 2'd3) state <= FILL_LOOK;
        end
        FILL_LOOK: begin
          if (min_val == code) begin
            next_rank <= next_rank + 1'b1;
            if (last) begin
              state <= FILL_DONE;
            end else begin
              code    <= code + 1'b1;
              min_val <= code + 1'b1;
              state   <= FILL_SCAN;
            end
          end else begin
            state <= FILL_COPY;
          end
        end
        FILL_COPY: begin
          if (last) begin
            state <= FILL_DONE;
          end else begin
            code    <= code + 1'b1;
            min_val <= code + 1'b1;
            state   <= FILL_SCAN;
          end
        end
        FILL_DONE: state <= FILL_DONE;
        default:   state <= FILL_DONE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_copy_from_earlier: assert property (@(posedge clk) disable iff (rst)
    (state == FILL_LOOK) && (min_val != code) |-> min_val < code)
    else $error("rank copy source not yet written");

  a_class_total: assert property (@(posedge clk) disable iff (rst)
    (state == FILL_DONE) |-> next_rank == RankW'(Classes16))
    else $error("rank fill produced wrong class count");
`endif

endmodule

// File: design/lbpm_back.sv
module lbpm_back import lbpm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cls_t              head,
  input  logic              in_empty,
  output logic              in_pop,
  output logic [RankAw-1:0] rank_raddr,
  input  logic [RankW-1:0]  rank_rdata,
  input  logic              pop,
  output logic              empty,
  output logic [LabelW-1:0] label,
  output logic [CountW-1:0] label_count,
  output logic              invalid
);

  logic              s1_valid;
  cls_t              s1_entry;
  logic [OutLvW-1:0] out_level;
  res_t              res;
  res_t              out_res;
  logic [$bits(res_t)-1:0] out_raw;

  // Issue only when the result buffer has room for everything in flight.
  assign in_pop = !in_empty &&
                  ((OutLvW + 1)'(out_level) + (OutLvW + 1)'(s1_valid) <
                   (OutLvW + 1)'(OutDepth));
  assign rank_raddr = head.label[RankAw-1:0];

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= in_pop;
  end

  always_ff @(posedge clk) begin
    if (in_pop) s1_entry <= head;
  end

  always_comb begin
    res.label   = s1_entry.use_rank ? LabelW'(rank_rdata) : s1_entry.label;
    res.count   = s1_entry.count;
    res.invalid = s1_entry.invalid;
  end

  lbpm_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OutDepth)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (res),
    .pop       (pop && !empty),
    .head      (out_raw),
    .empty     (empty),
    .level     (out_level)
  );

  assign out_res     = out_raw;
  assign label       = out_res.label;
  assign label_count = out_res.count;
  assign invalid     = out_res.invalid;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> out_level != OutLvW'(OutDepth))
    else $error("result buffer overflow");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && invalid |-> label == '0)
    else $error("invalid result with non-zero label");
`endif

endmodule

// File: design/lbp_pattern_label_mapper.sv
// Local binary pattern label mapper.
// Input channel: drive pattern and raise push; the item is taken at a clock edge
// where push is high and full is low. Output channel: while empty is low the
// oldest result sits on label, label_count and invalid; raise pop to take it.
// Configuration: cfg_index selects num_neighbors (0), uniform_mode (1),
// rot_inv (2) or average_bit (3); a write lands when cfg_valid and
// cfg_ready are both high (cfg_ready is always high). Other indexes are ignored.
// Write configuration only while no items are in flight.
// A taken item passes through the item queue, the lookup register and the
// result buffer. Throughput is one item per cycle while the receiver pops.
// Reset: configuration returns to 8 neighbours, plain mode. After reset the
// rank table for 16-neighbour rotation-invariant mode is built in place, one
// pattern at a time, and full stays high until the build is done.
// A stalled receiver fills the 3-entry result buffer and then the 4-entry
// item queue; full rises once both are taken up, and nothing is dropped.
module lbp_pattern_label_mapper import lbpm_pkg::*; #(
  parameter int unsigned MAX_NEIGHBORS = MaxNeighborsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic [PatternW-1:0]  pattern,
  input  logic                 pop,
  output logic                 empty,
  output logic [LabelW-1:0]    label,
  output logic [CountW-1:0]    label_count,
  output logic                 invalid
);

  cfg_t                  cfg;
  cls_t                  front_entry;
  logic [$bits(cls_t)-1:0] in_head_raw;
  cls_t                  in_head;
  logic                  in_empty;
  logic [QueueLvW-1:0]   in_level;
  logic                  in_pop;
  logic                  accept;
  logic [RankAw-1:0]     back_raddr;
  logic [RankW-1:0]      rank_rdata;
  logic                  fill_busy;

  // Configuration registers: always ready, out-of-range indexes drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_neighbors <= NeighborW'(8);
      cfg.uniform_mode  <= 1'b0;
      cfg.rot_inv       <= 1'b0;
      cfg.average_bit   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUM_NEIGHBORS: cfg.num_neighbors <= cfg_data[NeighborW-1:0];
        REG_UNIFORM_MODE:  cfg.uniform_mode  <= cfg_data[0];
        REG_ROT_INV:       cfg.rot_inv       <= cfg_data[0];
        REG_AVERAGE_BIT:   cfg.average_bit   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Hold off the input side until the queue has room and the rank table is built.
  assign full   = (in_level == QueueLvW'(QueueDepth)) || fill_busy;
  assign accept = push && !full;

  // Front: classify each pattern on arrival.
  lbpm_front #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_front (
    .cfg     (cfg),
    .pattern (pattern),
    .entry   (front_entry)
  );

  // Decouple classification from lookup and delivery.
  lbpm_queue #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (QueueDepth)
  ) u_in_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (front_entry),
    .pop       (in_pop),
    .head      (in_head_raw),
    .empty     (in_empty),
    .level     (in_level)
  );

  assign in_head = in_head_raw;

  // Back: rank lookup where needed, then the result buffer.
  lbpm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (in_head),
    .in_empty    (in_empty),
    .in_pop      (in_pop),
    .rank_raddr  (back_raddr),
    .rank_rdata  (rank_rdata),
    .pop         (pop),
    .empty       (empty),
    .label       (label),
    .label_count (label_count),
    .invalid     (invalid)
  );

  // The large rank table exists only when 16 neighbours are supported.
  generate
    if (MAX_NEIGHBORS >= LargeP) begin : g_rank
      fill_port_t        fill_port;
      logic [RankAw-1:0] ram_raddr;

      lbpm_rank_fill u_rank_fill (
        .clk   (clk),
        .rst   (rst),
        .rdata (rank_rdata),
        .port  (fill_port),
        .busy  (fill_busy)
      );

      // Hand the read port to the lookup path once the build is done.
      assign ram_raddr = fill_busy ? fill_port.raddr : back_raddr;

      lbpm_ram #(
        .WIDTH (RankW),
        .DEPTH (RankDepth)
      ) u_rank_ram (
        .clk   (clk),
        .we    (fill_port.we),
        .waddr (fill_port.waddr),
        .wdata (fill_port.wdata),
        .raddr (ram_raddr),
        .rdata (rank_rdata)
      );
    end else begin : g_no_rank
      assign fill_busy  = 1'b0;
      assign rank_rdata = '0;
    end
  endgenerate

endmodule

// File: test/lbp_pattern_label_mapper_tb.sv
module lbp_pattern_label_mapper_tb import lbpm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no handshake on any channel before the run is abandoned. The
  // rank table build after reset alone keeps full high, and the limit covers it.
  localparam int unsigned IdleLimit   = 1_600_000;
  localparam int unsigned MaxNbr      = MaxNeighborsDef;
  localparam int unsigned RandPhases  = 16;
  localparam int unsigned PhaseItems  = 120;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned PressItems  = 50;
  localparam int unsigned ReportLimit = 10;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;
  logic                 push;
  logic                 full;
  logic [PatternW-1:0]  pattern;
  logic                 pop;
  logic                 empty;
  logic [LabelW-1:0]    label;
  logic [CountW-1:0]    label_count;
  logic                 invalid;

  // One outstanding label: the pattern that caused it and what must come back.
  typedef struct packed {
    logic [PatternW-1:0] pat;
    res_t                res;
  } label_due_t;

  // One row of the directed table. Where typed is set the expected label,
  // count and invalid flag are given here; otherwise the predictor decides.
  typedef struct packed {
    logic [NeighborW-1:0] p;
    logic                 u;
    logic                 r;
    logic                 a;
    logic [PatternW-1:0]  pat;
    logic                 typed;
    logic [LabelW-1:0]    lab;
    logic [CountW-1:0]    cnt;
    logic                 inv;
  } dir_row_t;

  localparam int unsigned DirRows = 26;

  dir_row_t dir_rows [DirRows] = '{
    // reset setting: eight neighbours, plain
    '{8, 0, 0, 0, 16'h0000, 1, 0, 256, 0},
    '{8, 0, 0, 0, 16'h00FF, 1, 255, 256, 0},
    '{8, 0, 0, 0, 16'h0100, 1, 0, 256, 1},
    '{8, 0, 0, 0, 16'hFFFF, 1, 0, 256, 1},
    '{8, 0, 0, 0, 16'h00A5, 0, 0, 0, 0},
    // uniform: all zeros, all ones, a non-uniform pattern, a run of ones
    '{8, 1, 0, 0, 16'h0000, 1, 1, 59, 0},
    '{8, 1, 0, 0, 16'h00FF, 1, 58, 59, 0},
    '{8, 1, 0, 0, 16'h0055, 1, 0, 59, 0},
    '{8, 1, 0, 0, 16'h000F, 0, 0, 0, 0},
    // rotation-invariant uniform: label by ones count
    '{8, 1, 1, 0, 16'h0000, 1, 1, 10, 0},
    '{8, 1, 1, 0, 16'h00FF, 1, 9, 10, 0},
    '{8, 1, 1, 0, 16'h0038, 1, 4, 10, 0},
    // rotation-invariant plain: class ranks, first and last class
    '{8, 0, 1, 0, 16'h0000, 1, 0, 36, 0},
    '{8, 0, 1, 0, 16'h00FF, 1, 35, 36, 0},
    '{8, 0, 1, 0, 16'h0096, 0, 0, 0, 0},
    '{16, 0, 1, 0, 16'hFFFF, 1, 4115, 4116, 0},
    '{16, 0, 1, 0, 16'h1234, 0, 0, 0, 0},
    // uniform run wrapping round the top bit
    '{16, 1, 0, 0, 16'h8001, 0, 0, 0, 0},
    '{16, 0, 0, 0, 16'hFFFF, 1, 65535, 65536, 0},
    // average bit widens the plain pattern by one
    '{4, 0, 0, 1, 16'h001F, 1, 31, 32, 0},
    '{4, 0, 0, 1, 16'h0020, 1, 0, 32, 1},
    // average bit ignored outside plain mode, so bit 4 is overwide
    '{4, 1, 0, 1, 16'h0010, 1, 0, 15, 1},
    // unsupported settings
    '{16, 0, 0, 1, 16'h0000, 1, 0, 0, 1},
    '{5, 1, 0, 0, 16'h0003, 1, 0, 0, 1},
    '{3, 0, 0, 0, 16'h0001, 1, 0, 0, 1},
    '{17, 0, 0, 0, 16'h0001, 1, 0, 0, 1}
  };

  // Own copy of the configuration, updated as each write is taken.
  logic [NeighborW-1:0] nbr_cnt = 5'd8;
  logic                 uni_on  = 1'b0;
  logic                 rot_on  = 1'b0;
  logic                 avg_on  = 1'b0;

  // Rotation class ranks for 4, 8 and 16 neighbours, and class counts.
  logic [15:0] class_rank [3][65536];
  int unsigned class_total [3];

  label_due_t  labels_due [$];
  int unsigned err_count;
  int unsigned press_left;
  bit          quiet_sender;
  bit          hold_req;
  int unsigned idle_cycles = 0;

  lbp_pattern_label_mapper u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .pattern     (pattern),
    .pop         (pop),
    .empty       (empty),
    .label       (label),
    .label_count (label_count),
    .invalid     (invalid)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Walk patterns in ascending order; the first member met of each class is
  // its smallest, so hand out ranks in that order to every rotation at once.
  task automatic build_class_ranks();
    int unsigned sel;
    int unsigned p;
    int unsigned c;
    int unsigned s;
    int unsigned mask;
    int unsigned code;
    for (sel = 0; sel < 3; sel++) begin
      for (c = 0; c < 65536; c++) class_rank[sel][c] = 16'hFFFF;
    end
    for (sel = 0; sel < 3; sel++) begin
      p    = (sel == 0) ? 4 : (sel == 1) ? 8 : 16;
      mask = (1 << p) - 1;
      code = 0;
      for (c = 0; c < (1 << p); c++) begin
        if (class_rank[sel][c] == 16'hFFFF) begin
          for (s = 0; s < p; s++)
            class_rank[sel][16'(((c << s) | (c >> (p - s))) & mask)] = 16'(code);
          code++;
        end
      end
      class_total[sel] = code;
    end
  endtask

  // Label, label count and invalid flag for one pattern under the current
  // configuration copy.
  function automatic res_t map_pattern(input logic [PatternW-1:0] pat);
    res_t        res;
    int unsigned p;
    int unsigned width;
    int unsigned ones;
    int unsigned trans;
    int unsigned top;
    int unsigned sel;
    int unsigned i;
    bit          ok;
    bit          b;
    bit          nb;
    res = '0;
    p   = 32'(nbr_cnt);
    ok  = !(p < 4 || p > 16 || p > MaxNbr);
    if (ok && p != 4 && p != 8 && p != 16 && (uni_on || rot_on || avg_on)) ok = 1'b0;
    if (ok && p == 16 && avg_on) ok = 1'b0;
    if (!ok) begin
      res.invalid = 1'b1;
      return res;
    end
    width = (!uni_on && !rot_on && avg_on) ? p + 1 : p;
    sel   = (p == 4) ? 0 : (p == 8) ? 1 : 2;
    if (rot_on && uni_on) res.count = CountW'(p + 2);
    else if (rot_on) res.count = CountW'(class_total[sel]);
    else if (uni_on) res.count = CountW'(p * (p - 1) + 3);
    else res.count = CountW'(1 << width);
    // Overwide pattern: keep the count, drop the label.
    if ((32'(pat) >> width) != 0) begin
      res.invalid = 1'b1;
      return res;
    end
    if (uni_on) begin
      ones  = 0;
      trans = 0;
      top   = 0;
      for (i = 0; i < p; i++) begin
        b  = pat[i];
        nb = pat[(i + 1) % p];
        ones += 32'(b);
        if (b != nb) trans++;
        if (b && !nb) top = i;
      end
      if (trans > 2) res.label = '0;
      else if (ones == 0) res.label = LabelW'(1);
      else if (ones == p) res.label = rot_on ? LabelW'(p + 1) : LabelW'(p * (p - 1) + 2);
      else if (rot_on) res.label = LabelW'(1 + ones);
      else res.label = LabelW'(2 + (ones - 1) * p + (p - 1 - top));
    end else if (rot_on) begin
      res.label = class_rank[sel][pat];
    end else begin
      res.label = pat;
    end
    return res;
  endfunction

  // Random pattern for the given setting: mostly runs of ones and patterns
  // within the width, with some full-width noise that lands overwide.
  function automatic logic [PatternW-1:0] rand_pattern(input int unsigned p, input bit u,
                                                       input bit r, input bit a);
    int unsigned w;
    int unsigned pp;
    int unsigned k;
    int unsigned s;
    int unsigned x;
    int unsigned kind;
    w    = (!u && !r && a) ? p + 1 : p;
    if (w > 16) w = 16;
    pp   = (p >= 1 && p <= 16) ? p : 16;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      k = $urandom_range(0, pp);
      s = $urandom_range(0, pp - 1);
      x = (1 << k) - 1;
      return PatternW'(((x << s) | (x >> (pp - s))) & ((1 << pp) - 1));
    end
    if (kind < 75) return PatternW'($urandom & ((1 << w) - 1));
    if (kind < 85) return ($urandom_range(0, 1) == 1) ? PatternW'((1 << w) - 1) : '0;
    return PatternW'($urandom);
  endfunction

  // Offer one register write and hold it until taken; leave valid high so a
  // following write can go out on the next edge.
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_NUM_NEIGHBORS: nbr_cnt = val;
      REG_UNIFORM_MODE:  uni_on  = val[0];
      REG_ROT_INV:       rot_on  = val[0];
      REG_AVERAGE_BIT:   avg_on  = val[0];
      default: ;
    endcase
  endtask

  // Write all four registers; upper data bits of the flags carry noise, and
  // now and then a write to an unused index goes in as well.
  task automatic apply_settings(input int unsigned p, input bit u, input bit r, input bit a);
    write_reg(REG_NUM_NEIGHBORS, CfgDataW'(p));
    write_reg(REG_UNIFORM_MODE, {4'($urandom), u});
    write_reg(REG_ROT_INV, {4'($urandom), r});
    write_reg(REG_AVERAGE_BIT, {4'($urandom), a});
    if ($urandom_range(0, 1) == 1)
      write_reg(CfgIndexW'($urandom_range(4, 15)), CfgDataW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Lower push and wait until every outstanding label has come back.
  task automatic drain();
    push <= 1'b0;
    while (labels_due.size() != 0) @(posedge clk);
  endtask

  // Offer one pattern, record its expected label once taken, then sometimes idle.
  task automatic offer_item(input logic [PatternW-1:0] pat, input bit typed, input res_t given);
    label_due_t  due;
    int unsigned gap;
    int unsigned pick;
    pattern <= pat;
    push    <= 1'b1;
    do @(posedge clk); while (!(push && !full));
    due.pat = pat;
    due.res = typed ? given : map_pattern(pat);
    labels_due.push_back(due);
    gap = 0;
    if (press_left > 0) begin
      press_left--;
    end else if (!quiet_sender) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) gap = $urandom_range(1, 3);
      else if (pick < 30) gap = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Report a failure; only the first few are printed in full.
  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= ReportLimit) $display("%s", msg);
  endtask

  // Result side: take labels when present, idle at random, and honour a long
  // hold-off when the item side asks for one.
  initial begin : result_side
    int unsigned stall_left;
    int unsigned steady_left;
    int unsigned pick;
    label_due_t  due;
    stall_left  = 0;
    steady_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (labels_due.size() == 0) begin
          note_error($sformatf("label %0d count %0d invalid %0b with no item outstanding",
                               label, label_count, invalid));
        end else begin
          due = labels_due.pop_front();
          if (label !== due.res.label || label_count !== due.res.count ||
              invalid !== due.res.invalid)
            note_error($sformatf(
              "pattern %h: label %0d/%0d count %0d/%0d invalid %0b/%0b (expected/actual)",
              due.pat, due.res.label, label, due.res.count, label_count,
              due.res.invalid, invalid));
        end
      end
      if (hold_req) begin
        hold_req    = 1'b0;
        stall_left  = HoldCycles;
        steady_left = 0;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (steady_left > 0) begin
          steady_left--;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 3) steady_left = $urandom_range(40, 160);
          else if (pick < 25) stall_left = $urandom_range(1, 3);
          else if (pick < 28) stall_left = $urandom_range(8, 40);
        end
      end
    end
  end

  // Abandon the run after too long with no handshake anywhere.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : item_side
    int unsigned i;
    int unsigned ph;
    int unsigned j;
    int unsigned p;
    int unsigned pick;
    bit          u;
    bit          r;
    bit          a;
    dir_row_t    row;
    res_t        given;
    rst          <= 1'b1;
    push         <= 1'b0;
    pattern      <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    err_count    = 0;
    press_left   = 0;
    quiet_sender = 1'b0;
    hold_req     = 1'b0;
    build_class_ranks();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table; settings change only between drained groups of rows.
    for (i = 0; i < DirRows; i++) begin
      row = dir_rows[i];
      if (row.p != nbr_cnt || row.u != uni_on || row.r != rot_on || row.a != avg_on) begin
        drain();
        apply_settings(32'(row.p), row.u, row.r, row.a);
      end
      given.label   = row.lab;
      given.count   = row.cnt;
      given.invalid = row.inv;
      offer_item(row.pat, row.typed, given);
    end

    // Random phases, each under a fresh setting.
    for (ph = 0; ph < RandPhases; ph++) begin
      pick = $urandom_range(0, 11);
      p = 8;
      u = 1'b0;
      r = 1'b0;
      a = 1'b0;
      if (ph == 0) begin
        p = 16;
        r = 1'b1;
      end else if (ph == 1) begin
        p = 4;
        u = 1'b1;
      end else begin
        case (pick)
          0, 1, 2: begin
            p = 4 << $urandom_range(0, 2);
            r = 1'b1;
          end
          3, 4: begin
            p = 4 << $urandom_range(0, 2);
            u = 1'b1;
            r = 1'($urandom_range(0, 1));
            a = 1'($urandom_range(0, 1));
          end
          5: begin
            p = 4 << $urandom_range(0, 2);
            a = 1'($urandom_range(0, 1));
          end
          6, 7: p = $urandom_range(4, 16);
          8: p = 16;
          9: begin
            p = $urandom_range(0, 31);
            u = 1'($urandom_range(0, 1));
            r = 1'($urandom_range(0, 1));
            a = 1'($urandom_range(0, 1));
          end
          10: begin
            p = $urandom_range(5, 15);
            if (p == 8) p = 9;
            u = 1'($urandom_range(0, 1));
            r = !u;
          end
          default: begin
            p = 4;
            a = 1'b1;
          end
        endcase
      end
      drain();
      apply_settings(p, u, r, a);
      quiet_sender = ($urandom_range(0, 3) == 0);
      for (j = 0; j < PhaseItems; j++) begin
        // Starve the result side while items keep coming back to back.
        if (ph == 0 && j == 20) begin
          hold_req   = 1'b1;
          press_left = PressItems;
        end
        offer_item(rand_pattern(p, u, r, a), 1'b0, '0);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (err_count == 0 && labels_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
